@@ sv/hsi2rgbw_pkg.sv @@
// ----------------------------------------------------------------------------
// hsi2rgbw_pkg
// Shared widths, sector codes and stage enable bundle for the hsi to rgbw
// colour converter.
// ----------------------------------------------------------------------------
package hsi2rgbw_pkg;

  // field widths fixed by the item format
  localparam int HUE_W = 11;
  localparam int CH_W  = 8;
  localparam int SI_W  = 16;

  // which pair of colour channels a hue sector drives (primary, next)
  typedef enum logic [1:0] {
    SECT_RG = 2'd0,
    SECT_GB = 2'd1,
    SECT_BR = 2'd2
  } sector_t;

  // per-stage load enables, stage 1 sits right behind the input port
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

@@ sv/hsi2rgbw_hue_split.sv @@
// ----------------------------------------------------------------------------
// hsi2rgbw_hue_split
// Splits the hue into a sector code and an offset inside the sector over
// stages 1 to 3, using reciprocal multiplies with one correction step.
// ----------------------------------------------------------------------------
module hsi2rgbw_hue_split #(
  parameter int SECTOR_STEPS
) (
  input  logic                                clk,
  input  hsi2rgbw_pkg::stage_en_t             en,
  input  logic [hsi2rgbw_pkg::HUE_W-1:0]      in_hue,
  output logic [$clog2(SECTOR_STEPS)-1:0]     offset,
  output hsi2rgbw_pkg::sector_t               sector
);

  localparam int HW     = hsi2rgbw_pkg::HUE_W;
  localparam int TW     = $clog2(SECTOR_STEPS);
  localparam int QMAX   = ((1 << HW) - 1) / SECTOR_STEPS;
  localparam int QW     = $clog2(QMAX + 2);
  localparam int RS     = HW + 1;
  localparam int RECIP  = (1 << RS) / SECTOR_STEPS;
  localparam int RCW    = $clog2(RECIP + 1);
  localparam int MW     = ((TW + 2) > (HW + 1)) ? (TW + 2) : (HW + 1);
  localparam int R3S    = QW + 2;
  localparam int RECIP3 = (1 << R3S) / 3;
  localparam int R3W    = $clog2(RECIP3 + 1);

  logic [HW-1:0]     hue1_r;
  logic [QW-1:0]     qest1_r;
  logic [TW-1:0]     offset2_r;
  logic [QW-1:0]     quot2_r;
  hsi2rgbw_pkg::sector_t sector3_r;

  logic [HW+RCW-1:0] est_prod;
  logic [QW-1:0]     qest_nxt;
  logic [MW-1:0]     back;
  logic [MW-1:0]     rem;
  logic              fix;
  logic [TW-1:0]     offset_nxt;
  logic [QW-1:0]     quot_nxt;
  logic [QW+R3W-1:0] q3_prod;
  logic [QW+1:0]     q3;
  logic [QW+1:0]     rem3;
  logic [QW+1:0]     sec_val;
  hsi2rgbw_pkg::sector_t sector_nxt;

  // stage 1: estimate of hue / sector_steps, low by at most one
  assign est_prod = (HW + RCW)'(in_hue) * (HW + RCW)'(RECIP);
  assign qest_nxt = QW'(est_prod >> RS);

  // stage 2: remainder and one correction step
  always_comb begin
    back       = MW'(qest1_r) * MW'(SECTOR_STEPS);
    rem        = MW'(hue1_r) - back;
    fix        = (rem >= MW'(SECTOR_STEPS));
    offset_nxt = fix ? TW'(rem - MW'(SECTOR_STEPS)) : TW'(rem);
    quot_nxt   = qest1_r + QW'(fix);
  end

  // stage 3: sector index modulo three wraps hue values past the circle
  always_comb begin
    q3_prod = (QW + R3W)'(quot2_r) * (QW + R3W)'(RECIP3);
    q3      = (QW + 2)'(q3_prod >> R3S);
    rem3    = (QW + 2)'(quot2_r) - q3 * (QW + 2)'(3);
    sec_val = (rem3 >= (QW + 2)'(3)) ? (rem3 - (QW + 2)'(3)) : rem3;
    sector_nxt = hsi2rgbw_pkg::sector_t'(sec_val[1:0]);
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en.s1) begin
      hue1_r  <= in_hue;
      qest1_r <= qest_nxt;
    end
    if (en.s2) begin
      offset2_r <= offset_nxt;
      quot2_r   <= quot_nxt;
    end
    if (en.s3) begin
      sector3_r <= sector_nxt;
    end
  end

  assign offset = offset2_r;
  assign sector = sector3_r;

endmodule

@@ sv/hsi2rgbw_ratio_rom.sv @@
// ----------------------------------------------------------------------------
// hsi2rgbw_ratio_rom
// Constant table of k = cos(t)/cos(60deg - t) over one sector in signed
// fixed point, built at elaboration, read through a registered port.
// ----------------------------------------------------------------------------
module hsi2rgbw_ratio_rom #(
  parameter int SECTOR_STEPS,
  parameter int RATIO_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [$clog2(SECTOR_STEPS)-1:0]      addr,
  output logic signed [RATIO_FRAC_BITS+2:0]    ratio
);

  localparam int KW = RATIO_FRAC_BITS + 3;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] PI3_Q30 = 64'd1124419809;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] SPAN    = 64'(3 * SECTOR_STEPS);
  localparam logic [63:0] COS_DIV [1:14] = '{
    64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };

  // q2.30 cosine, fifteen taylor terms, each truncated
  function automatic logic signed [63:0] cos_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x2) >> 30) / COS_DIV[n];
      if (n[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    return sum;
  endfunction

  // shift and subtract division for table building
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] part;
    logic [63:0] quo;
    part = '0;
    quo  = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[63:0], a[i]};
      if (part >= {1'b0, b}) begin
        part   = part - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // one table entry, rounded to nearest with ties away from zero
  function automatic logic signed [KW-1:0] ratio_entry(input int t);
    logic [63:0]        theta;
    logic [63:0]        aphi;
    logic [63:0]        mag;
    logic [63:0]        den_u;
    logic [63:0]        quo;
    logic signed [63:0] phi;
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic signed [63:0] quo_s;
    theta = (64'(t) * 64'd2 * PI_Q30 + SPAN / 2) / SPAN;
    phi   = $signed(PI3_Q30) - $signed(theta);
    aphi  = (phi < 0) ? $unsigned(-phi) : $unsigned(phi);
    num   = cos_q30(theta);
    den   = cos_q30(aphi);
    if (den <= 0) den = 64'sd1;
    mag   = (num < 0) ? $unsigned(-num) : $unsigned(num);
    den_u = $unsigned(den);
    quo   = udiv64((mag << RATIO_FRAC_BITS) + (den_u >> 1), den_u);
    quo_s = $signed(quo);
    return KW'((num < 0) ? -quo_s : quo_s);
  endfunction

  logic signed [KW-1:0] rom_tab [SECTOR_STEPS];
  logic signed [KW-1:0] ratio_r;

  // table contents
  for (genvar g = 0; g < SECTOR_STEPS; g++) begin : g_tab
    localparam logic signed [KW-1:0] ENTRY = ratio_entry(g);
    assign rom_tab[g] = ENTRY;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (en) begin
      ratio_r <= rom_tab[addr];
    end
  end

  assign ratio = ratio_r;

endmodule

@@ sv/hsi2rgbw_level.sv @@
// ----------------------------------------------------------------------------
// hsi2rgbw_level
// Weights s*i by (1+k) and (2-k), divides by 765 and routes the primary and
// next levels onto red, green and blue by sector (stages 4 and 5).
// ----------------------------------------------------------------------------
module hsi2rgbw_level #(
  parameter int RATIO_FRAC_BITS
) (
  input  logic                                clk,
  input  hsi2rgbw_pkg::stage_en_t             en,
  input  logic [hsi2rgbw_pkg::SI_W-1:0]       si,
  input  logic signed [RATIO_FRAC_BITS+2:0]   ratio,
  input  hsi2rgbw_pkg::sector_t               sector,
  output logic [hsi2rgbw_pkg::CH_W-1:0]       red,
  output logic [hsi2rgbw_pkg::CH_W-1:0]       green,
  output logic [hsi2rgbw_pkg::CH_W-1:0]       blue
);

  localparam int F      = RATIO_FRAC_BITS;
  localparam int KW     = F + 3;
  localparam int WW     = F + 2;
  localparam int SW     = hsi2rgbw_pkg::SI_W;
  localparam int CW     = hsi2rgbw_pkg::CH_W;
  localparam int PW     = SW + WW;
  localparam int XW     = 18;
  localparam int DIV_SH = 28;
  localparam int DIV_MUL = ((1 << DIV_SH) + 764) / 765;
  localparam int DMW    = 19;
  localparam int QPW    = XW + DMW;
  localparam int LW     = QPW - DIV_SH;
  localparam logic signed [KW:0] ONE_K = (KW + 1)'(64'd1 << F);

  logic [PW-1:0]         prodp_r;
  logic [PW-1:0]         prodn_r;
  hsi2rgbw_pkg::sector_t sec4_r;
  logic [CW-1:0]         red_r;
  logic [CW-1:0]         green_r;
  logic [CW-1:0]         blue_r;

  logic signed [KW:0]    wp_s;
  logic signed [KW:0]    wn_s;
  logic [WW-1:0]         wp;
  logic [WW-1:0]         wn;
  logic [PW-1:0]         prodp_nxt;
  logic [PW-1:0]         prodn_nxt;
  logic [XW-1:0]         xp;
  logic [XW-1:0]         xn;
  logic [LW-1:0]         qp;
  logic [LW-1:0]         qn;
  logic [CW-1:0]         prim;
  logic [CW-1:0]         nxt;
  logic [CW-1:0]         red_nxt;
  logic [CW-1:0]         green_nxt;
  logic [CW-1:0]         blue_nxt;

  // stage 4: weights clamped at zero, then s*i times weight
  always_comb begin
    wp_s = ONE_K + (KW + 1)'(ratio);
    wn_s = (ONE_K <<< 1) - (KW + 1)'(ratio);
    wp   = (wp_s < 0) ? '0 : WW'(wp_s);
    wn   = (wn_s < 0) ? '0 : WW'(wn_s);
    prodp_nxt = PW'(si) * PW'(wp);
    prodn_nxt = PW'(si) * PW'(wn);
  end

  // stage 5: divide by 765 * 2^F as a shift and a reciprocal multiply
  always_comb begin
    xp   = XW'(prodp_r >> F);
    xn   = XW'(prodn_r >> F);
    qp   = LW'((QPW'(xp) * QPW'(DIV_MUL)) >> DIV_SH);
    qn   = LW'((QPW'(xn) * QPW'(DIV_MUL)) >> DIV_SH);
    prim = (qp > LW'(255)) ? CW'(255) : CW'(qp);
    nxt  = (qn > LW'(255)) ? CW'(255) : CW'(qn);
  end

  // route primary and next levels by sector
  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    unique case (sec4_r)
      hsi2rgbw_pkg::SECT_RG: begin
        red_nxt   = prim;
        green_nxt = nxt;
      end
      hsi2rgbw_pkg::SECT_GB: begin
        green_nxt = prim;
        blue_nxt  = nxt;
      end
      hsi2rgbw_pkg::SECT_BR: begin
        blue_nxt  = prim;
        red_nxt   = nxt;
      end
      default: begin
        red_nxt   = '0;
        green_nxt = '0;
        blue_nxt  = '0;
      end
    endcase
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en.s4) begin
      prodp_r <= prodp_nxt;
      prodn_r <= prodn_nxt;
      sec4_r  <= sector;
    end
    if (en.s5) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

@@ sv/hsi_to_rgbw_convert_unit.sv @@
// ----------------------------------------------------------------------------
// hsi_to_rgbw_convert_unit
// Hue, saturation and intensity to red, green, blue and white drive levels,
// five-stage pipeline with per-stage valid bits.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  in_hue[10:0], in_saturation[7:0], in_intensity[7:0]
//  out      out_valid / out_stall  out_red, out_green, out_blue, out_white [7:0]
//
//  one item per cycle while out_stall is low, five register stages; an item
//  accepted into stage 1 moves through stages 2 to 5, where it raises out_valid
//  the ratio table read sits in stage 3; stages 4 and 5 hold the weight and
//  divide multipliers, which set the stage depth
//  a stage loads when it is empty or the stage after it moves, so bubbles
//  close up under out_stall; in_stall rises only with all five stages full
//  and out_stall high
//  reset clears the valid bits only
module hsi_to_rgbw_convert_unit #(
  parameter int SECTOR_STEPS    = 512,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hsi2rgbw_pkg::HUE_W-1:0]     in_hue,
  input  logic [hsi2rgbw_pkg::CH_W-1:0]      in_saturation,
  input  logic [hsi2rgbw_pkg::CH_W-1:0]      in_intensity,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hsi2rgbw_pkg::CH_W-1:0]      out_red,
  output logic [hsi2rgbw_pkg::CH_W-1:0]      out_green,
  output logic [hsi2rgbw_pkg::CH_W-1:0]      out_blue,
  output logic [hsi2rgbw_pkg::CH_W-1:0]      out_white
);

  localparam int TW       = $clog2(SECTOR_STEPS);
  localparam int KW       = RATIO_FRAC_BITS + 3;
  localparam int SW       = hsi2rgbw_pkg::SI_W;
  localparam int CW       = hsi2rgbw_pkg::CH_W;
  localparam int NSTAGE   = 5;
  localparam int WHITE_SH = 25;
  localparam int WHITE_MW = 18;
  localparam int WHITE_W  = SW + WHITE_MW;
  localparam int WHITE_MUL = ((1 << WHITE_SH) + 254) / 255;

  hsi2rgbw_pkg::stage_en_t en;
  logic [NSTAGE-1:0]       go;
  logic [NSTAGE-1:0]       valid_r;
  logic [NSTAGE-1:0]       valid_nxt;

  logic [SW-1:0]  si1_r;
  logic [SW-1:0]  wi1_r;
  logic [SW-1:0]  si2_r;
  logic [SW-1:0]  si3_r;
  logic [CW-1:0]  white2_r;
  logic [CW-1:0]  white3_r;
  logic [CW-1:0]  white4_r;
  logic [CW-1:0]  white5_r;
  logic [CW-1:0]  white_nxt;

  logic [TW-1:0]           offset;
  hsi2rgbw_pkg::sector_t   sector;
  logic signed [KW-1:0]    ratio;

  // stage enables ripple back from the output
  always_comb begin
    en.s5 = !valid_r[4] || !out_stall;
    en.s4 = !valid_r[3] || en.s5;
    en.s3 = !valid_r[2] || en.s4;
    en.s2 = !valid_r[1] || en.s3;
    en.s1 = !valid_r[0] || en.s2;
    go    = {en.s5, en.s4, en.s3, en.s2, en.s1};
  end

  // valid bits move with the data
  always_comb begin
    valid_nxt[0] = go[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      valid_nxt[k] = go[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // white level, (255-s)*i/255 by reciprocal multiply
  assign white_nxt = CW'((WHITE_W'(wi1_r) * WHITE_W'(WHITE_MUL)) >> WHITE_SH);

  // s*i and white path registers
  always_ff @(posedge clk) begin
    if (en.s1) begin
      si1_r <= SW'(in_saturation) * SW'(in_intensity);
      wi1_r <= SW'(8'd255 - in_saturation) * SW'(in_intensity);
    end
    if (en.s2) begin
      si2_r    <= si1_r;
      white2_r <= white_nxt;
    end
    if (en.s3) begin
      si3_r    <= si2_r;
      white3_r <= white2_r;
    end
    if (en.s4) begin
      white4_r <= white3_r;
    end
    if (en.s5) begin
      white5_r <= white4_r;
    end
  end

  // hue to sector and offset
  hsi2rgbw_hue_split #(
    .SECTOR_STEPS (SECTOR_STEPS)
  ) u_hue_split (
    .clk    (clk),
    .en     (en),
    .in_hue (in_hue),
    .offset (offset),
    .sector (sector)
  );

  // ratio table lookup
  hsi2rgbw_ratio_rom #(
    .SECTOR_STEPS    (SECTOR_STEPS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_ratio_rom (
    .clk   (clk),
    .en    (en.s3),
    .addr  (offset),
    .ratio (ratio)
  );

  // channel levels
  hsi2rgbw_level #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_level (
    .clk    (clk),
    .en     (en),
    .si     (si3_r),
    .ratio  (ratio),
    .sector (sector),
    .red    (out_red),
    .green  (out_green),
    .blue   (out_blue)
  );

  assign in_stall  = !en.s1;
  assign out_valid = valid_r[NSTAGE-1];
  assign out_white = white5_r;

`ifndef NO_ASSERTIONS
  // input stalls only when every stage holds an item and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&valid_r) && out_stall))
    else $error("input stalled with a free stage");

  // one colour channel is always dark
  a_one_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == '0 || out_green == '0 || out_blue == '0))
    else $error("all three colour channels lit");

  // a taken result is replaced by the item waiting in stage 4
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && valid_r[3]) |=> out_valid)
    else $error("pipeline did not advance into the output stage");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item present after reset");
`endif

endmodule

@@ dv/tb_hsi_to_rgbw_convert_unit.sv @@
// ----------------------------------------------------------------------------
// tb_hsi_to_rgbw_convert_unit
// Self-checking bench for the hsi to rgbw converter. A short directed set
// covers sector edges, hue wrap and the zero saturation or intensity cases.
// Random items follow under three idling mixes and one long output hold-off.
// A scoreboard computes each item's drive levels from its own ratio table
// and checks every result, in order, field by field.
// ----------------------------------------------------------------------------
module tb_hsi_to_rgbw_convert_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_W           = hsi2rgbw_pkg::HUE_W;
  localparam int CH_W            = hsi2rgbw_pkg::CH_W;
  localparam int SECTOR_STEPS    = 512;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int HUE_SPAN        = 3 * SECTOR_STEPS;
  localparam int RANDOM_PER_MIX  = 150;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] white;
  } rgbw_levels_t;

  // expected drive levels for every accepted item, oldest first
  class rgbw_scoreboard;
    longint       ratio_lut[SECTOR_STEPS];
    rgbw_levels_t pending_levels[$];
    int           mismatch_count;

    function new();
      mismatch_count = 0;
      for (int t = 0; t < SECTOR_STEPS; t++) begin
        ratio_lut[t] = sector_ratio(t);
      end
    endfunction

    // q2.30 cosine, truncated taylor sum of fifteen terms
    function automatic longint cos_q30(longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned n;
      longint          acc;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      acc  = 64'sd1 << 30;
      for (n = 1; n <= 14; n++) begin
        term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
        if (n[0]) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      return acc;
    endfunction

    // k = cos(t) / cos(60deg - t), rounded to nearest, ties away from zero
    function automatic longint sector_ratio(int t);
      longint unsigned span;
      longint unsigned theta;
      longint unsigned phi_mag;
      longint unsigned mag;
      longint unsigned uden;
      longint unsigned q;
      longint          phi;
      longint          num;
      longint          den;
      span    = longint'(HUE_SPAN);
      theta   = (longint'(t) * 64'd2 * 64'd3373259426 + span / 2) / span;
      phi     = 64'sd1124419809 - longint'(theta);
      phi_mag = (phi < 0) ? longint'(-phi) : longint'(phi);
      num     = cos_q30(theta);
      den     = cos_q30(phi_mag);
      if (den <= 0) den = 1;
      uden = den;
      mag  = (num < 0) ? longint'(-num) : longint'(num);
      q    = ((mag << RATIO_FRAC_BITS) + uden / 2) / uden;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // s*i scaled by a q.16 weight over 765, clamped to a channel
    function automatic logic [CH_W-1:0] weighted_level(longint si, longint w);
      longint v;
      if (w < 0) w = 0;
      v = (si * w) / (64'sd765 << RATIO_FRAC_BITS);
      if (v > 255) v = 255;
      return v[CH_W-1:0];
    endfunction

    function automatic rgbw_levels_t predict_levels(int hue, int sat, int inten);
      rgbw_levels_t          lv;
      hsi2rgbw_pkg::sector_t sect;
      int                    h;
      longint                k;
      longint                si;
      longint                one;
      logic [CH_W-1:0]       prim;
      logic [CH_W-1:0]       nxt;
      h    = hue % HUE_SPAN;
      sect = hsi2rgbw_pkg::sector_t'(h / SECTOR_STEPS);
      k    = ratio_lut[h % SECTOR_STEPS];
      one  = 64'sd1 << RATIO_FRAC_BITS;
      si   = longint'(sat) * longint'(inten);
      prim = weighted_level(si, one + k);
      nxt  = weighted_level(si, 2 * one - k);
      lv.red   = '0;
      lv.green = '0;
      lv.blue  = '0;
      case (sect)
        hsi2rgbw_pkg::SECT_RG: begin
          lv.red   = prim;
          lv.green = nxt;
        end
        hsi2rgbw_pkg::SECT_GB: begin
          lv.green = prim;
          lv.blue  = nxt;
        end
        default: begin
          lv.blue = prim;
          lv.red  = nxt;
        end
      endcase
      lv.white = CH_W'(((255 - sat) * inten) / 255);
      return lv;
    endfunction

    function void note_input(int hue, int sat, int inten);
      pending_levels.push_back(predict_levels(hue, sat, inten));
    endfunction

    function void check_field(string name, logic [CH_W-1:0] exp_v,
                              logic [CH_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                               logic [CH_W-1:0] b, logic [CH_W-1:0] w);
      rgbw_levels_t lv;
      if (pending_levels.size() == 0) begin
        $error("result with no item outstanding: r=%0d g=%0d b=%0d w=%0d",
               r, g, b, w);
        mismatch_count++;
      end else begin
        lv = pending_levels.pop_front();
        check_field("red", lv.red, r);
        check_field("green", lv.green, g);
        check_field("blue", lv.blue, b);
        check_field("white", lv.white, w);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [HUE_W-1:0]  in_hue;
  logic [CH_W-1:0]   in_saturation;
  logic [CH_W-1:0]   in_intensity;
  logic              out_valid;
  logic              out_stall;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic [CH_W-1:0]   out_white;

  int                send_idle_pct;
  int                recv_idle_pct;
  logic              pressure_go;
  logic              hold_off;
  int                cycle_cnt;
  rgbw_scoreboard    sb;

  hsi_to_rgbw_convert_unit #(
    .SECTOR_STEPS    (SECTOR_STEPS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_intensity  (in_intensity),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_white     (out_white)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // known values on every input from time zero
  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_intensity  = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_go   = 1'b0;
    hold_off      = 1'b0;
    cycle_cnt     = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check accepted items, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_red, out_green, out_blue, out_white);
      end
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // long output hold-off while the sender keeps offering items
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one item, returns at the edge that accepts it
  task automatic send_item(input int hue, input int sat, input int inten);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue[HUE_W-1:0];
    in_saturation <= sat[CH_W-1:0];
    in_intensity  <= inten[CH_W-1:0];
    do @(posedge clk); while (in_stall);
    sb.note_input(hue, sat, inten);
  endtask

  // saturation or intensity, biased towards the extremes now and then
  function automatic int pick_level();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 255 : 0;
    return $urandom_range(0, 255);
  endfunction

  task automatic send_random(input int count);
    int hue;
    for (int n = 0; n < count; n++) begin
      // mostly in range, a few wrapping past a full circle
      if ($urandom_range(0, 19) == 0) hue = $urandom_range(HUE_SPAN, 2047);
      else hue = $urandom_range(0, HUE_SPAN - 1);
      send_item(hue, pick_level(), pick_level());
    end
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first mix: sender idles a little, receiver a lot
    send_idle_pct = 19;
    recv_idle_pct = 48;

    // sector edges and the midpoint where both weights match
    send_item(0, 255, 255);
    send_item(1, 255, 255);
    send_item(256, 255, 255);
    send_item(511, 255, 255);
    send_item(512, 255, 255);
    send_item(1023, 255, 255);
    send_item(1024, 255, 255);
    send_item(1535, 255, 255);
    send_item(768, 200, 100);
    send_item(1280, 128, 64);
    // hue wrapping past a full circle
    send_item(1536, 255, 255);
    send_item(1700, 77, 200);
    send_item(2047, 255, 255);
    // zero saturation or intensity
    send_item(100, 0, 255);
    send_item(700, 255, 0);
    send_item(1200, 0, 0);
    send_item(0, 0, 255);
    // small and near-full levels
    send_item(255, 1, 1);
    send_item(1000, 254, 255);
    send_item(1400, 255, 1);

    send_random(RANDOM_PER_MIX);

    // second mix: roles swapped
    send_idle_pct = 48;
    recv_idle_pct = 19;
    send_random(RANDOM_PER_MIX);

    // third mix: no idling, with one long output hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_go   = 1'b1;
    send_random(RANDOM_PER_MIX);
    in_valid <= 1'b0;

    // drain
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.pending_levels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/hsi2rgbw_pkg.sv
sv/hsi2rgbw_hue_split.sv
sv/hsi2rgbw_ratio_rom.sv
sv/hsi2rgbw_level.sv
sv/hsi_to_rgbw_convert_unit.sv
dv/tb_hsi_to_rgbw_convert_unit.sv
